/* design/s2a_pkg.sv */
// ----------------------------------------------------------------------------
// s2a_pkg: shared definitions for the signed integer to decimal text core
// Widths, character codes and the item types that pass between the
// front, the queue, the binary to BCD converter and the character emitter.
// ----------------------------------------------------------------------------
package s2a_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_WIDTH = NUM_DIGITS * 4;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_WIDTH = CONV_STEPS * BITS_PER_STEP;
  localparam int STEP_CNT_WIDTH = $clog2(CONV_STEPS + 1);
  localparam int DIGIT_IDX_WIDTH = $clog2(NUM_DIGITS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef struct packed {
    logic                   negative;
    logic [VALUE_WIDTH-1:0] magnitude;
  } item_t;

  typedef struct packed {
    logic                 negative;
    logic [BCD_WIDTH-1:0] bcd;
  } conv_t;

endpackage

/* design/signed_int_to_decimal_ascii_core.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core: signed integer to decimal text
// Converts each two's-complement input value into its decimal ASCII text.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, value) takes one 32-bit signed value
// per transfer. The output channel (out_valid, out_stall, character,
// last_char) sends that value's text one character per transfer: an optional
// '-', then the digits, most significant first, with no leading zeros. Zero
// gives the single character '0'. last_char is set on the final character of
// each value, and no terminator follows it.
// The first character follows the input transfer once the value has passed
// through the input register, the queue, the converter, which handles four
// magnitude bits per cycle, and the handoff to the emitter. After that one
// character leaves per cycle while the receiver does not stall. Conversion
// of the next value overlaps the emission of the current one, so a steady
// stream is paced by the converter's 8 steps plus its handoff and by the
// one-character-per-cycle emitter.
// A synchronous reset empties the input register, the queue, the converter
// and the emitter. When the receiver stalls, the current character holds,
// and the input side accepts until the queue and the input register fill.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [s2a_pkg::VALUE_WIDTH-1:0] value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [7:0]                             character,
  output logic                                   last_char
);

  logic           fq_valid;
  logic           fq_stall;
  s2a_pkg::item_t fq_item;
  logic           qc_valid;
  logic           qc_stall;
  s2a_pkg::item_t qc_item;
  logic           ce_valid;
  logic           ce_stall;
  s2a_pkg::conv_t ce_conv;

  s2a_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .q_valid  (fq_valid),
    .q_stall  (fq_stall),
    .q_item   (fq_item)
  );

  s2a_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_stall  (fq_stall),
    .in_item   (fq_item),
    .out_valid (qc_valid),
    .out_stall (qc_stall),
    .out_item  (qc_item)
  );

  s2a_bcd u_bcd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (qc_valid),
    .in_stall  (qc_stall),
    .in_item   (qc_item),
    .out_valid (ce_valid),
    .out_stall (ce_stall),
    .out_conv  (ce_conv)
  );

  s2a_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ce_valid),
    .in_stall  (ce_stall),
    .in_conv   (ce_conv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last_char (last_char)
  );

endmodule

/* design/s2a_front.sv */
// ----------------------------------------------------------------------------
// s2a_front: input stage
// Accepts one value per transfer, splits it into sign and magnitude and
// holds the result in a register until the queue takes it.
// ----------------------------------------------------------------------------
module s2a_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [s2a_pkg::VALUE_WIDTH-1:0] value,
  output logic                                 q_valid,
  input  logic                                 q_stall,
  output s2a_pkg::item_t                       q_item
);

  logic           full;
  s2a_pkg::item_t item;
  logic           take;
  logic           negative;
  logic [s2a_pkg::VALUE_WIDTH-1:0] magnitude;

  assign negative = value[s2a_pkg::VALUE_WIDTH-1];
  assign magnitude = negative ? ((~value) + {{(s2a_pkg::VALUE_WIDTH-1){1'b0}}, 1'b1})
                              : value;

  assign in_stall = full && q_stall;
  assign take = in_valid && !in_stall;
  assign q_valid = full;
  assign q_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (take) begin
      full <= 1'b1;
    end else if (!q_stall) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.negative <= negative;
      item.magnitude <= magnitude;
    end
  end

endmodule

/* design/s2a_queue.sv */
// ----------------------------------------------------------------------------
// s2a_queue: short item queue
// Decouples the input stage from the converter so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module s2a_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  s2a_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output s2a_pkg::item_t out_item
);

  s2a_pkg::item_t                   slots [s2a_pkg::QUEUE_DEPTH];
  logic [s2a_pkg::QPTR_WIDTH-1:0]   wr_ptr;
  logic [s2a_pkg::QPTR_WIDTH-1:0]   rd_ptr;
  logic [s2a_pkg::QCNT_WIDTH-1:0]   count;
  logic                             push;
  logic                             pop;

  assign in_stall = (count == s2a_pkg::QCNT_WIDTH'(s2a_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_item = slots[rd_ptr];
  assign push = in_valid && !in_stall;
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        if (wr_ptr == s2a_pkg::QPTR_WIDTH'(s2a_pkg::QUEUE_DEPTH - 1)) begin
          wr_ptr <= '0;
        end else begin
          wr_ptr <= wr_ptr + 1'b1;
        end
      end
      if (pop) begin
        if (rd_ptr == s2a_pkg::QPTR_WIDTH'(s2a_pkg::QUEUE_DEPTH - 1)) begin
          rd_ptr <= '0;
        end else begin
          rd_ptr <= rd_ptr + 1'b1;
        end
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

/* design/s2a_bcd.sv */
// ----------------------------------------------------------------------------
// s2a_bcd: binary to BCD converter
// Shift-and-add-three conversion of the magnitude, four bits per cycle.
// ----------------------------------------------------------------------------
module s2a_bcd (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  s2a_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output s2a_pkg::conv_t out_conv
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                              state;
  logic [s2a_pkg::STEP_CNT_WIDTH-1:0]  steps;
  logic [s2a_pkg::PAD_WIDTH-1:0]       shift;
  logic [s2a_pkg::BCD_WIDTH-1:0]       bcd;
  logic                                negative;
  logic [s2a_pkg::PAD_WIDTH-1:0]       shift_next;
  logic [s2a_pkg::BCD_WIDTH-1:0]       bcd_next;
  logic                                take;

  function automatic logic [s2a_pkg::BCD_WIDTH-1:0] dabble_step(
    input logic [s2a_pkg::BCD_WIDTH-1:0] bcd_in,
    input logic                          bit_in
  );
    logic [s2a_pkg::BCD_WIDTH-1:0] adj;
    adj = bcd_in;
    for (int i = 0; i < s2a_pkg::NUM_DIGITS; i++) begin
      if (adj[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
      end
    end
    return {adj[s2a_pkg::BCD_WIDTH-2:0], bit_in};
  endfunction

  assign in_stall = !((state == S_IDLE) || ((state == S_DONE) && !out_stall));
  assign take = in_valid && !in_stall;
  assign out_valid = (state == S_DONE);
  assign out_conv.negative = negative;
  assign out_conv.bcd = bcd;

  always_comb begin
    bcd_next = bcd;
    shift_next = shift;
    for (int k = 0; k < s2a_pkg::BITS_PER_STEP; k++) begin
      bcd_next = dabble_step(bcd_next, shift_next[s2a_pkg::PAD_WIDTH-1]);
      shift_next = {shift_next[s2a_pkg::PAD_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      steps <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            state <= S_RUN;
            steps <= '0;
          end
        end
        S_RUN: begin
          steps <= steps + 1'b1;
          if (steps == s2a_pkg::STEP_CNT_WIDTH'(s2a_pkg::CONV_STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_RUN;
            steps <= '0;
          end else if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      negative <= in_item.negative;
      shift <= s2a_pkg::PAD_WIDTH'(in_item.magnitude);
      bcd <= '0;
    end else if (state == S_RUN) begin
      shift <= shift_next;
      bcd <= bcd_next;
    end
  end

endmodule

/* design/s2a_emit.sv */
// ----------------------------------------------------------------------------
// s2a_emit: character emitter
// Sends the sign and the decimal digits of one converted value, most
// significant first, one character per transfer, without leading zeros.
// ----------------------------------------------------------------------------
module s2a_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  s2a_pkg::conv_t in_conv,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     character,
  output logic           last_char
);

  logic                                 active;
  logic                                 sign_pending;
  logic [s2a_pkg::DIGIT_IDX_WIDTH-1:0]  pos;
  logic [3:0]                           digits [s2a_pkg::NUM_DIGITS];
  logic [s2a_pkg::DIGIT_IDX_WIDTH-1:0]  lead;
  logic                                 final_char;
  logic                                 send;
  logic                                 take;

  assign final_char = !sign_pending && (pos == '0);
  assign send = active && !out_stall;
  assign in_stall = active && !(send && final_char);
  assign take = in_valid && !in_stall;

  assign out_valid = active;
  assign character = sign_pending ? s2a_pkg::CHAR_MINUS
                                  : (s2a_pkg::CHAR_ZERO + {4'h0, digits[pos]});
  assign last_char = final_char;

  always_comb begin
    lead = '0;
    for (int i = 0; i < s2a_pkg::NUM_DIGITS; i++) begin
      if (in_conv.bcd[i*4 +: 4] != 4'd0) begin
        lead = s2a_pkg::DIGIT_IDX_WIDTH'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      sign_pending <= 1'b0;
      pos <= '0;
    end else if (take) begin
      active <= 1'b1;
      sign_pending <= in_conv.negative;
      pos <= lead;
    end else if (send) begin
      if (final_char) begin
        active <= 1'b0;
      end else if (sign_pending) begin
        sign_pending <= 1'b0;
      end else begin
        pos <= pos - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < s2a_pkg::NUM_DIGITS; i++) begin
        digits[i] <= in_conv.bcd[i*4 +: 4];
      end
    end
  end

endmodule

/* design/s2a_checker.sv */
// ----------------------------------------------------------------------------
// s2a_checker: port-level checks for the decimal text core
// Watches the output channel for handshake rules and text format.
// ----------------------------------------------------------------------------
module s2a_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] character,
  input logic       last_char
);

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Output valid dropped during a stall.");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(character) && $stable(last_char))
    else $error("Output payload changed during a stall.");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == s2a_pkg::CHAR_MINUS) ||
                  ((character >= s2a_pkg::CHAR_ZERO) && (character <= s2a_pkg::CHAR_NINE)))
    else $error("Output character is neither a sign nor a digit.");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (character == s2a_pkg::CHAR_MINUS) |-> !last_char)
    else $error("A minus sign ended the text.");

  a_no_leading_zero: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && !out_stall && (character == s2a_pkg::CHAR_MINUS)) && out_valid
    |-> character != s2a_pkg::CHAR_ZERO)
    else $error("A zero digit followed the minus sign.");

endmodule

bind signed_int_to_decimal_ascii_core s2a_checker u_checker (.*);

/* tb/sv/tb_signed_int_to_decimal_ascii_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_core: self-checking bench for the text core
// Feeds 32-bit signed values through the input channel and checks every
// character that leaves the output channel against a predicted text stream.
// A short directed run covers the extremes, zero and the most negative value.
// Random runs follow, with idle and stall mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_core;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  class text_scoreboard;
    logic [7:0] exp_char [$];
    logic       exp_last [$];
    int         errors = 0;

    function void note_value(logic [s2a_pkg::VALUE_WIDTH-1:0] v);
      logic [s2a_pkg::VALUE_WIDTH-1:0] mag;
      logic [3:0]                      digit [0:s2a_pkg::NUM_DIGITS-1];
      int                              nd;
      mag = v[s2a_pkg::VALUE_WIDTH-1] ? ~v + 1'b1 : v;
      nd = 0;
      if (mag == 0) begin
        exp_char.push_back(s2a_pkg::CHAR_ZERO);
        exp_last.push_back(1'b1);
        return;
      end
      while (mag != 0) begin
        digit[nd] = 4'(mag % 10);
        nd++;
        mag = mag / 10;
      end
      if (v[s2a_pkg::VALUE_WIDTH-1]) begin
        exp_char.push_back(s2a_pkg::CHAR_MINUS);
        exp_last.push_back(1'b0);
      end
      for (int k = nd - 1; k >= 0; k--) begin
        exp_char.push_back(s2a_pkg::CHAR_ZERO + digit[k]);
        exp_last.push_back(k == 0);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      logic [7:0] want_char;
      logic       want_last;
      if (exp_char.size() == 0) begin
        $display("%0t: unexpected character, expected none, actual %h last %b",
                 $time, ch, last);
        errors++;
      end else begin
        want_char = exp_char.pop_front();
        want_last = exp_last.pop_front();
        if (ch !== want_char) begin
          $display("%0t: character mismatch, expected %h, actual %h",
                   $time, want_char, ch);
          errors++;
        end
        if (last !== want_last) begin
          $display("%0t: last_char mismatch, expected %b, actual %b",
                   $time, want_last, last);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return exp_char.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [s2a_pkg::VALUE_WIDTH-1:0] value;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [7:0]                      character;
  logic                            last_char;

  text_scoreboard text_sb;
  int idle_pct;
  int stall_pct;
  int hold_request = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  logic [s2a_pkg::VALUE_WIDTH-1:0] directed_values [0:19] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd999999999, 32'd1000000000,
    -32'sd999999999, -32'sd1000000000, 32'hAAAA_AAAA, 32'h5555_5555,
    32'd1234567890, -32'sd123456789
  };

  signed_int_to_decimal_ascii_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last_char (last_char)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_request) begin
      hold_served <= hold_request;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      text_sb.note_value(value);
    end
    if (!rst && out_valid && !out_stall) begin
      text_sb.check_char(character, last_char);
    end
  end

  function automatic logic [s2a_pkg::VALUE_WIDTH-1:0] random_value();
    int     kind;
    int     ndig;
    longint lo;
    longint hi;
    longint mag;
    longint r;
    kind = $urandom_range(9);
    if (kind < 3) begin
      return $urandom;
    end
    if (kind == 9) begin
      ndig = $urandom_range(9);
      mag = 1;
      repeat (ndig) mag = mag * 10;
      mag = mag - $urandom_range(1);
      if ($urandom_range(3) == 0) begin
        mag = 64'd2147483648 - $urandom_range(1);
      end
    end else begin
      ndig = $urandom_range(1, 10);
      lo = 1;
      repeat (ndig - 1) lo = lo * 10;
      hi = lo * 10 - 1;
      if (hi > 64'd2147483647) begin
        hi = 64'd2147483647;
      end
      r = $urandom;
      mag = lo + r % (hi - lo + 1);
    end
    if ($urandom_range(1) == 1) begin
      mag = -mag;
    end
    return mag[s2a_pkg::VALUE_WIDTH-1:0];
  endfunction

  task automatic send_value(input logic [s2a_pkg::VALUE_WIDTH-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int send_idle, input int recv_stall);
    idle_pct = send_idle;
    stall_pct <= recv_stall;
    repeat (count) send_value(random_value());
  endtask

  initial begin
    text_sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_values[i]) send_value(directed_values[i]);
    run_phase(120, 0, 0);
    run_phase(110, 60, 0);
    run_phase(110, 0, 60);
    run_phase(70, 10, 10);
    // The output is held off for a long stretch while values keep coming.
    hold_request <= hold_request + 1;
    run_phase(40, 0, 0);
    in_valid <= 1'b0;
    stall_pct <= 0;
    while (text_sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (text_sb.errors == 0 && text_sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
